@@ rtl/core/lscd_pkg.sv @@
// ----------------------------------------------------------------------------
// lscd_pkg
// Types, codes and helper functions shared by the keyed substitution decoder.
// ----------------------------------------------------------------------------
package lscd_pkg;

   localparam int unsigned AlphaSize = 62;
   localparam int unsigned IdxWidth  = 6;
   localparam int unsigned KeyWidth  = 8;
   localparam int unsigned CharWidth = 8;
   localparam int unsigned StatWidth = 2;
   localparam int unsigned CsrIdxWidth = 2;

   // Scaled reciprocal of 62 for the remainder unit: floor(2^16 / 62).
   localparam int unsigned RecipShift = 16;
   localparam logic [10:0] RECIP_62 = 11'd1057;

   localparam logic [IdxWidth-1:0] ALPHA_LAST = 6'(AlphaSize - 1);

   localparam logic [0:0] CMD_REBUILD = 1'b0;
   localparam logic [0:0] CMD_DECODE  = 1'b1;

   localparam logic [StatWidth-1:0] STATUS_OK        = 2'd0;
   localparam logic [StatWidth-1:0] STATUS_BAD_SYM   = 2'd1;
   localparam logic [StatWidth-1:0] STATUS_NOT_READY = 2'd2;

   localparam logic [CsrIdxWidth-1:0] CSR_CIPHER_KEY    = 2'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_SECRET_LENGTH = 2'd1;

   localparam logic [KeyWidth-1:0] KEY_RESET    = 8'd5;
   localparam logic [KeyWidth-1:0] LENGTH_RESET = 8'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_RED,
      ST_PROBE,
      ST_LOOKUP
   } st_type;

   typedef enum logic [1:0] {
      RSP_REBUILT,
      RSP_NOT_READY,
      RSP_BAD_SYM,
      RSP_LOOKUP
   } rsp_sel_type;

   typedef struct packed {
      logic        start_rebuild;
      logic        mul_en;
      logic        red_en;
      logic        probe_en;
      logic        dec_read;
      logic        rsp_load;
      rsp_sel_type rsp_sel;
   } dp_cmd_type;

   typedef struct packed {
      logic used_hit;
      logic last_pos;
      logic table_ready;
      logic symbol_valid;
   } dp_stat_type;

   function automatic logic symbol_in_alphabet(input logic [CharWidth-1:0] c);
      symbol_in_alphabet = (c >= 8'h30 && c <= 8'h39) ||
                           (c >= 8'h61 && c <= 8'h7a) ||
                           (c >= 8'h41 && c <= 8'h5a);
   endfunction

   // Only meaningful for symbols inside the alphabet.
   function automatic logic [IdxWidth-1:0] symbol_index(input logic [CharWidth-1:0] c);
      logic [CharWidth-1:0] t;
      t = 8'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         t = c - 8'h30;
      end else if (c >= 8'h61 && c <= 8'h7a) begin
         t = c - 8'h61 + 8'd10;
      end else if (c >= 8'h41 && c <= 8'h5a) begin
         t = c - 8'h41 + 8'd36;
      end
      symbol_index = t[IdxWidth-1:0];
   endfunction

   function automatic logic [CharWidth-1:0] alpha_char(input logic [IdxWidth-1:0] idx);
      logic [CharWidth-1:0] w;
      w = {2'b00, idx};
      if (w < 8'd10) begin
         alpha_char = w + 8'h30;
      end else if (w < 8'd36) begin
         alpha_char = w - 8'd10 + 8'h61;
      end else if (w < 8'd62) begin
         alpha_char = w - 8'd36 + 8'h41;
      end else begin
         alpha_char = 8'd0;
      end
   endfunction

endpackage

@@ rtl/core/lscd_datapath.sv @@
// ----------------------------------------------------------------------------
// lscd_datapath
// Configuration registers, LCG remainder unit, used map, inverse table
// memory and the result register.
// ----------------------------------------------------------------------------
module lscd_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_valid,
   input  logic [lscd_pkg::CsrIdxWidth-1:0]    csr_index,
   input  logic [lscd_pkg::KeyWidth-1:0]       csr_data,
   input  logic [lscd_pkg::CharWidth-1:0]      req_symbol,
   input  lscd_pkg::dp_cmd_type                cmd,
   output lscd_pkg::dp_stat_type               stat,
   output logic [lscd_pkg::CharWidth-1:0]      rsp_char,
   output logic [lscd_pkg::StatWidth-1:0]      rsp_status
);

   logic [lscd_pkg::KeyWidth-1:0]  key_ff, key_in;
   logic [lscd_pkg::KeyWidth-1:0]  len_ff, len_in;
   logic [11:0]                    x_ff, x_in;
   logic [6:0]                     q_ff, q_in;
   logic [lscd_pkg::IdxWidth-1:0]  v_ff, v_in;
   logic [lscd_pkg::IdxWidth-1:0]  pos_ff, pos_in;
   logic [lscd_pkg::AlphaSize-1:0] used_ff, used_in;
   logic                           ready_ff, ready_in;
   logic [lscd_pkg::IdxWidth-1:0]  rd_ff;
   logic [lscd_pkg::CharWidth-1:0] char_ff, char_in;
   logic [lscd_pkg::StatWidth-1:0] status_ff, status_in;

   logic [lscd_pkg::IdxWidth-1:0]  inv_mem [lscd_pkg::AlphaSize];

   logic [8:0]  seed_sum;
   logic [11:0] seed_x;
   logic [11:0] next_x;
   logic [22:0] prod;
   logic [11:0] qm;
   logic [11:0] rem;
   logic [11:0] rem_fix;
   logic        used_hit;
   logic        place;

   assign used_hit = used_ff[v_ff];
   assign place    = cmd.probe_en && !used_hit;

   // 69 is congruent to 7 modulo 62, so the multiplier is reduced up front.
   assign seed_sum = {1'b0, len_ff} + {1'b0, key_ff};
   assign seed_x   = ({3'b000, seed_sum} << 3) - {3'b000, seed_sum} + {4'h0, key_ff};
   assign next_x   = ({6'd0, v_ff} << 3) - {6'd0, v_ff} + {4'h0, key_ff};

   // Quotient estimate is exact or one low; the remainder needs one correction.
   assign prod    = 23'(x_ff) * 23'(lscd_pkg::RECIP_62);
   assign qm      = ({5'd0, q_ff} << 6) - ({5'd0, q_ff} << 1);
   assign rem     = x_ff - qm;
   assign rem_fix = (rem >= 12'd62) ? (rem - 12'd62) : rem;

   always_comb begin
      key_in    = key_ff;
      len_in    = len_ff;
      x_in      = x_ff;
      q_in      = q_ff;
      v_in      = v_ff;
      pos_in    = pos_ff;
      used_in   = used_ff;
      ready_in  = ready_ff;
      char_in   = char_ff;
      status_in = status_ff;

      if (csr_valid) begin
         if (csr_index == lscd_pkg::CSR_CIPHER_KEY) begin
            key_in = csr_data;
         end else if (csr_index == lscd_pkg::CSR_SECRET_LENGTH) begin
            len_in = csr_data;
         end
      end

      if (cmd.start_rebuild) begin
         x_in    = seed_x;
         pos_in  = '0;
         used_in = '0;
      end
      if (cmd.mul_en) begin
         q_in = prod[22:lscd_pkg::RecipShift];
      end
      if (cmd.red_en) begin
         v_in = rem_fix[lscd_pkg::IdxWidth-1:0];
      end
      if (cmd.probe_en) begin
         if (used_hit) begin
            v_in = (v_ff == lscd_pkg::ALPHA_LAST) ? '0 : v_ff + 6'd1;
         end else begin
            used_in[v_ff] = 1'b1;
            x_in          = next_x;
            pos_in        = pos_ff + 6'd1;
            if (pos_ff == lscd_pkg::ALPHA_LAST) begin
               ready_in = 1'b1;
            end
         end
      end

      if (cmd.rsp_load) begin
         unique case (cmd.rsp_sel)
            lscd_pkg::RSP_REBUILT: begin
               char_in   = '0;
               status_in = lscd_pkg::STATUS_OK;
            end
            lscd_pkg::RSP_NOT_READY: begin
               char_in   = '0;
               status_in = lscd_pkg::STATUS_NOT_READY;
            end
            lscd_pkg::RSP_BAD_SYM: begin
               char_in   = '0;
               status_in = lscd_pkg::STATUS_BAD_SYM;
            end
            lscd_pkg::RSP_LOOKUP: begin
               char_in   = lscd_pkg::alpha_char(rd_ff);
               status_in = lscd_pkg::STATUS_OK;
            end
            default: begin
               char_in   = '0;
               status_in = lscd_pkg::STATUS_OK;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff   <= lscd_pkg::KEY_RESET;
         len_ff   <= lscd_pkg::LENGTH_RESET;
         used_ff  <= '0;
         ready_ff <= 1'b0;
         pos_ff   <= '0;
      end else begin
         key_ff   <= key_in;
         len_ff   <= len_in;
         used_ff  <= used_in;
         ready_ff <= ready_in;
         pos_ff   <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff      <= x_in;
      q_ff      <= q_in;
      v_ff      <= v_in;
      char_ff   <= char_in;
      status_ff <= status_in;
   end

   // Inverse table: written once per placed entry, read once per decode that reaches it.
   always_ff @(posedge clock) begin
      if (place) begin
         inv_mem[v_ff] <= pos_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.dec_read) begin
         rd_ff <= inv_mem[lscd_pkg::symbol_index(req_symbol)];
      end
   end

   assign stat.used_hit     = used_hit;
   assign stat.last_pos     = (pos_ff == lscd_pkg::ALPHA_LAST);
   assign stat.table_ready  = ready_ff;
   assign stat.symbol_valid = lscd_pkg::symbol_in_alphabet(req_symbol);

   assign rsp_char   = char_ff;
   assign rsp_status = status_ff;

endmodule

@@ rtl/core/lscd_ctrl.sv @@
// ----------------------------------------------------------------------------
// lscd_ctrl
// Sequencer for rebuild walks and decode lookups, and the stream handshakes.
// ----------------------------------------------------------------------------
module lscd_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic                  req_command,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  lscd_pkg::dp_stat_type stat,
   output lscd_pkg::dp_cmd_type  cmd
);

   lscd_pkg::st_type state_ff, state_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             slot_free;
   logic             accept;

   // The result register is free when empty or being drained this cycle.
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == lscd_pkg::ST_IDLE) && slot_free;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         lscd_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_command == lscd_pkg::CMD_REBUILD) begin
                  state_in = lscd_pkg::ST_MUL;
               end else if (stat.table_ready && stat.symbol_valid) begin
                  state_in = lscd_pkg::ST_LOOKUP;
               end
            end
         end
         lscd_pkg::ST_MUL:    state_in = lscd_pkg::ST_RED;
         lscd_pkg::ST_RED:    state_in = lscd_pkg::ST_PROBE;
         lscd_pkg::ST_PROBE: begin
            if (!stat.used_hit) begin
               state_in = stat.last_pos ? lscd_pkg::ST_IDLE : lscd_pkg::ST_MUL;
            end
         end
         lscd_pkg::ST_LOOKUP: state_in = lscd_pkg::ST_IDLE;
         default:             state_in = lscd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '{start_rebuild: 1'b0, mul_en: 1'b0, red_en: 1'b0, probe_en: 1'b0,
              dec_read: 1'b0, rsp_load: 1'b0, rsp_sel: lscd_pkg::RSP_REBUILT};
      unique case (state_ff)
         lscd_pkg::ST_IDLE: begin
            if (accept) begin
               if (req_command == lscd_pkg::CMD_REBUILD) begin
                  cmd.start_rebuild = 1'b1;
               end else if (!stat.table_ready) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_sel  = lscd_pkg::RSP_NOT_READY;
               end else if (!stat.symbol_valid) begin
                  cmd.rsp_load = 1'b1;
                  cmd.rsp_sel  = lscd_pkg::RSP_BAD_SYM;
               end else begin
                  cmd.dec_read = 1'b1;
               end
            end
         end
         lscd_pkg::ST_MUL: cmd.mul_en = 1'b1;
         lscd_pkg::ST_RED: cmd.red_en = 1'b1;
         lscd_pkg::ST_PROBE: begin
            cmd.probe_en = 1'b1;
            if (!stat.used_hit && stat.last_pos) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_sel  = lscd_pkg::RSP_REBUILT;
            end
         end
         lscd_pkg::ST_LOOKUP: begin
            cmd.rsp_load = 1'b1;
            cmd.rsp_sel  = lscd_pkg::RSP_LOOKUP;
         end
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lscd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

@@ rtl/core/lcg_substitution_cipher_decoder_unit.sv @@
// ----------------------------------------------------------------------------
// lcg_substitution_cipher_decoder_unit
// Keyed permutation of the 62-symbol alphabet 0-9a-zA-Z with decode lookup.
//
//   Channel | Direction | Contents
//   req     | in        | tuser: command; tdata: symbol
//   rsp     | out       | tdata: decoded_char; tuser: status
//   csr     | in        | index 0 cipher_key, 1 secret_length; data 8 bits
//
// A decode that reaches the table goes through the registered read of the
// inverse table memory, then the mapping of the position to its character
// into the result register. A decode that is flagged has its result loaded
// at the accepting edge. A rebuild loads its seed at the accepting edge, then
// walks 62 entries, each through the multiply and reduce steps of the shared
// remainder unit and a probe step, plus one more probe per occupied slot.
// Reset clears the tables' ready flag; a new request is taken while a
// result is still waiting, as long as it is drained in the same cycle.
// ----------------------------------------------------------------------------
module lcg_substitution_cipher_decoder_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [lscd_pkg::CharWidth-1:0]   req_tdata,   // [7:0] symbol
   input  logic                             req_tuser,   // [0] command
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [lscd_pkg::CharWidth-1:0]   rsp_tdata,   // [7:0] decoded_char
   output logic [lscd_pkg::StatWidth-1:0]   rsp_tuser,   // [1:0] status
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [lscd_pkg::CsrIdxWidth-1:0] csr_index,
   input  logic [lscd_pkg::KeyWidth-1:0]    csr_data
);

   lscd_pkg::dp_cmd_type  cmd;
   lscd_pkg::dp_stat_type stat;

   assign csr_ready = 1'b1;

   lscd_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_command (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .stat        (stat),
      .cmd         (cmd)
   );

   lscd_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_symbol (req_tdata),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_char   (rsp_tdata),
      .rsp_status (rsp_tuser)
   );

endmodule

@@ tb/tb.sv @@
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the keyed substitution decoder unit.
//
// Requests are sent through the req stream, and the key and length registers
// are written through the csr channel. Every result on the rsp stream is
// checked against a behavioral copy of the decoder kept in this module. The
// run covers decodes before any table build, alphabet boundaries, register
// extremes, writes to unused register indexes and stale tables after a
// register change. Random traffic then runs under several sender and
// receiver stall patterns.
// ----------------------------------------------------------------------------
module tb;

   localparam int unsigned StallLimit  = 50000;
   localparam int unsigned DrainCycles = 8;
   localparam int unsigned LcgMult     = 69;
   localparam int unsigned PhaseItems  = 225;
   localparam int unsigned CharBits    = lscd_pkg::CharWidth;
   localparam int unsigned KeyBits     = lscd_pkg::KeyWidth;

   // Register indexes past the end of the map. Writes to them are ignored.
   localparam logic [lscd_pkg::CsrIdxWidth-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [lscd_pkg::CsrIdxWidth-1:0] CSR_SPARE_B = 2'd3;

   typedef struct packed {
      logic [lscd_pkg::CharWidth-1:0] ch;
      logic [lscd_pkg::StatWidth-1:0] status;
   } rsp_item_type;

   logic                             clock      = 1'b0;
   logic                             reset      = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [lscd_pkg::CharWidth-1:0]   req_tdata  = '0;
   logic                             req_tuser  = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [lscd_pkg::CharWidth-1:0]   rsp_tdata;
   logic [lscd_pkg::StatWidth-1:0]   rsp_tuser;
   logic                             csr_valid  = 1'b0;
   logic                             csr_ready;
   logic [lscd_pkg::CsrIdxWidth-1:0] csr_index  = '0;
   logic [lscd_pkg::KeyWidth-1:0]    csr_data   = '0;

   // Behavioral copy of the decoder.
   logic [lscd_pkg::KeyWidth-1:0] key_m        = lscd_pkg::KEY_RESET;
   logic [lscd_pkg::KeyWidth-1:0] len_m        = lscd_pkg::LENGTH_RESET;
   logic [lscd_pkg::IdxWidth-1:0] inv_m [lscd_pkg::AlphaSize];
   logic                          tables_built = 1'b0;

   rsp_item_type pending_rsp [$];
   int unsigned  errors        = 0;
   int unsigned  send_idle_pct = 0;
   int unsigned  rsp_stall_pct = 0;
   int unsigned  quiet_cycles  = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   lcg_substitution_cipher_decoder_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Alphabet order is digits, then lower case, then upper case.
   function automatic int alpha_position(input logic [lscd_pkg::CharWidth-1:0] c);
      if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
      if (c >= 8'h61 && c <= 8'h7a) return int'(c) - 'h61 + 10;
      if (c >= 8'h41 && c <= 8'h5a) return int'(c) - 'h41 + 36;
      return -1;
   endfunction

   function automatic logic [lscd_pkg::CharWidth-1:0] alpha_code(input int unsigned i);
      if (i < 10) return CharBits'(32'h30 + i);
      if (i < 36) return CharBits'(32'h61 + i - 10);
      return CharBits'(32'h41 + i - 36);
   endfunction

   function automatic void build_permutation();
      int unsigned                   k;
      int unsigned                   v;
      logic [lscd_pkg::AlphaSize-1:0] taken;
      k     = 32'(key_m);
      v     = (LcgMult * (32'(len_m) + k) + k) % lscd_pkg::AlphaSize;
      taken = '0;
      for (int pos = 0; pos < lscd_pkg::AlphaSize; pos++) begin
         if (pos > 0) begin
            // Probe forward past every entry that is already placed.
            v = (LcgMult * v + k) % lscd_pkg::AlphaSize;
            while (taken[v[lscd_pkg::IdxWidth-1:0]]) v = (v + 1) % lscd_pkg::AlphaSize;
         end
         inv_m[v[lscd_pkg::IdxWidth-1:0]] = pos[lscd_pkg::IdxWidth-1:0];
         taken[v[lscd_pkg::IdxWidth-1:0]] = 1'b1;
      end
      tables_built = 1'b1;
   endfunction

   function automatic rsp_item_type predict_response(
      input logic cmd, input logic [lscd_pkg::CharWidth-1:0] sym);
      rsp_item_type r;
      int           a;
      r.ch     = '0;
      r.status = lscd_pkg::STATUS_OK;
      if (cmd == lscd_pkg::CMD_REBUILD) begin
         build_permutation();
      end else if (!tables_built) begin
         r.status = lscd_pkg::STATUS_NOT_READY;
      end else begin
         a = alpha_position(sym);
         if (a < 0) begin
            r.status = lscd_pkg::STATUS_BAD_SYM;
         end else begin
            r.ch = alpha_code(32'(inv_m[a[lscd_pkg::IdxWidth-1:0]]));
         end
      end
      return r;
   endfunction

   function automatic logic [lscd_pkg::CharWidth-1:0] random_symbol();
      if ($urandom_range(99) < 80) return alpha_code($urandom_range(lscd_pkg::AlphaSize - 1));
      return CharBits'($urandom_range(255));
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("MISMATCH at %0t: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
      errors++;
   endtask

   task automatic send_item(input logic cmd, input logic [lscd_pkg::CharWidth-1:0] sym);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      pending_rsp.push_back(predict_response(cmd, sym));
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= sym;
      do @(posedge clock); while (!(req_tvalid && req_tready));
   endtask

   // Stops the request stream and waits until every result has come back.
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_csr(input logic [lscd_pkg::CsrIdxWidth-1:0] idx,
                            input logic [lscd_pkg::KeyWidth-1:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      @(posedge clock);
      unique case (idx)
         lscd_pkg::CSR_CIPHER_KEY: begin
            key_m = val;
         end
         lscd_pkg::CSR_SECRET_LENGTH: begin
            len_m = val;
         end
         default: begin
         end
      endcase
   endtask

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin : check_rsp
      rsp_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_rsp.size() == 0) begin
            report_mismatch("result with nothing pending", 32'(rsp_tdata), 0);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_tdata !== want.ch) begin
               report_mismatch("decoded_char", 32'(rsp_tdata), 32'(want.ch));
            end
            if (rsp_tuser !== want.status) begin
               report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
            end
         end
      end
   end

   // Ends the run if no transfer of any kind happens for too long.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= StallLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Decodes before the first build must report that the tables are not ready,
   // even for symbols outside the alphabet.
   task automatic test_before_build();
      send_item(lscd_pkg::CMD_DECODE, 8'h30);
      send_item(lscd_pkg::CMD_DECODE, 8'h5a);
      send_item(lscd_pkg::CMD_DECODE, 8'h00);
      send_item(lscd_pkg::CMD_DECODE, 8'hff);
   endtask

   task automatic test_alphabet_edges();
      logic [lscd_pkg::CharWidth-1:0] edges [15];
      edges = '{8'h30, 8'h39, 8'h61, 8'h7a, 8'h41, 8'h5a, 8'h2f, 8'h3a,
                8'h60, 8'h7b, 8'h40, 8'h5b, 8'h00, 8'hff, 8'h80};
      send_item(lscd_pkg::CMD_REBUILD, 8'h00);
      foreach (edges[i]) send_item(lscd_pkg::CMD_DECODE, edges[i]);
      send_item(lscd_pkg::CMD_REBUILD, 8'hff);
      send_item(lscd_pkg::CMD_DECODE, 8'h30);
   endtask

   // Register extremes. The first decode after each change still uses the old
   // tables, and the writes to the unused indexes must have no effect.
   task automatic test_register_extremes();
      logic [lscd_pkg::KeyWidth-1:0] keys [5];
      logic [lscd_pkg::KeyWidth-1:0] lens [5];
      keys = '{8'd0, 8'd255, 8'd0, 8'd255, lscd_pkg::KEY_RESET};
      lens = '{8'd0, 8'd255, 8'd255, 8'd0, lscd_pkg::LENGTH_RESET};
      foreach (keys[i]) begin
         wait_idle();
         write_csr(lscd_pkg::CSR_CIPHER_KEY, keys[i]);
         write_csr(lscd_pkg::CSR_SECRET_LENGTH, lens[i]);
         write_csr(CSR_SPARE_A, KeyBits'($urandom_range(255)));
         write_csr(CSR_SPARE_B, KeyBits'($urandom_range(255)));
         send_item(lscd_pkg::CMD_DECODE, random_symbol());
         send_item(lscd_pkg::CMD_REBUILD, CharBits'($urandom_range(255)));
         repeat (5) send_item(lscd_pkg::CMD_DECODE, random_symbol());
      end
   endtask

   task automatic test_random_traffic();
      int unsigned idle_pcts  [4];
      int unsigned stall_pcts [4];
      idle_pcts  = '{0, 54, 0, 8};
      stall_pcts = '{0, 0, 54, 8};
      foreach (idle_pcts[p]) begin
         wait_idle();
         write_csr(lscd_pkg::CSR_CIPHER_KEY, KeyBits'($urandom_range(255)));
         write_csr(lscd_pkg::CSR_SECRET_LENGTH, KeyBits'($urandom_range(255)));
         send_idle_pct = idle_pcts[p];
         rsp_stall_pct = stall_pcts[p];
         send_item(lscd_pkg::CMD_REBUILD, CharBits'($urandom_range(255)));
         for (int n = 0; n < PhaseItems; n++) begin
            // Hold the request stream halfway through until all results return.
            if (n == PhaseItems / 2) wait_idle();
            if ($urandom_range(99) < 4) begin
               send_item(lscd_pkg::CMD_REBUILD, CharBits'($urandom_range(255)));
            end else begin
               send_item(lscd_pkg::CMD_DECODE, random_symbol());
            end
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_before_build();
      test_alphabet_edges();
      test_register_extremes();
      test_random_traffic();
      wait_idle();
      if (errors == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/core/lscd_pkg.sv
rtl/core/lscd_datapath.sv
rtl/core/lscd_ctrl.sv
rtl/core/lcg_substitution_cipher_decoder_unit.sv
tb/tb.sv
